// File: rtl/core/raycast_wall_strip_projection_macros.svh
// Assertion macros for the raycast wall strip projection block.
// Used by the top level only; expands to nothing under synthesis.
`ifndef RAYCAST_WALL_STRIP_PROJECTION_MACROS_SVH
`define RAYCAST_WALL_STRIP_PROJECTION_MACROS_SVH

`ifndef SYNTHESIS

`define RWSP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rwsp assertion failed");

`define RWSP_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rwsp forbidden condition seen");

`else

`define RWSP_ASSERT(lbl, prop)

`define RWSP_ASSERT_NEVER(lbl, cond)

`endif

`endif

// File: rtl/core/rwsp_pkg.sv
// Shared constants, types and the cosine table for the wall strip projection.
// No dependencies; every module file refers to this package by scoped names.
package rwsp_pkg;

    localparam int NUM_COLUMNS = 1024;
    localparam int SCREEN_ROWS = 1024;
    localparam int COS_DEPTH   = 256;
    localparam int COS_IDX_W   = $clog2(COS_DEPTH);

    localparam int COL_W      = 10;
    localparam int DIST_W     = 24;
    localparam int ANGLE_W    = 16;
    localparam int ROW_W      = 11;
    localparam int COLOUR_W   = 32;
    localparam int SCALE_W    = 24;
    localparam int MAG_W      = 15;
    localparam int COS_FRAC   = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int REM_W          = DIST_W + 1;
    localparam int DIV_CELLS      = SCALE_W;
    localparam int RESULT_LATENCY = DIV_CELLS + 5;
    localparam int SPAN_W         = $clog2(3 * SCREEN_ROWS) + 2;

    localparam logic [SCALE_W-1:0]  SCALE_RESET        = 24'd14529536;
    localparam logic [COLOUR_W-1:0] VERT_COLOUR_RESET  = 32'hFFFFFFFF;
    localparam logic [COLOUR_W-1:0] HORIZ_COLOUR_RESET = 32'hFFCCCCCC;

    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE       = 2'd0,
        REG_VERT_COLOUR = 2'd1,
        REG_HORIZ_COLOUR = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } cos_entry_t;

    typedef cos_entry_t [COS_DEPTH-1:0] cos_rom_t;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] column;
        logic             vert;
        logic             empty;
        logic             full;
    } ray_t;

    typedef struct packed {
        ray_t               ray;
        logic [DIST_W-1:0]  rem;
        logic [SCALE_W-1:0] dividend;
        logic [DIST_W-1:0]  divisor;
        logic [SCALE_W-1:0] quot;
    } div_t;

    function automatic cos_entry_t cos_entry(input int unsigned k);
        logic [63:0]        m;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        q;
        logic signed [63:0] sum;
        logic               neg;
        cos_entry_t         e;
        m = (2 * k <= COS_DEPTH) ? 64'(k) : 64'(COS_DEPTH - k);
        x = (64'd2 * PI_Q30 * m + 64'(COS_DEPTH / 2)) / 64'(COS_DEPTH);
        neg = 1'b0;
        if (x > HALF_PI_Q30)
        begin
            x = (x > PI_Q30) ? 64'd0 : PI_Q30 - x;
            neg = 1'b1;
        end
        x2 = (x * x) >> 30;
        term = ONE_Q30;
        sum = $signed(ONE_Q30);
        term = ((term * x2) >> 30) / 64'd2;
        sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd12;
        sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd30;
        sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd56;
        sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd90;
        sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd132;
        sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd182;
        sum = sum - $signed(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        q = ($unsigned(sum) + 64'd16384) >> 15;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        e.mag = q[MAG_W-1:0];
        e.neg = neg && (q != 64'd0);
        return e;
    endfunction

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        for (int unsigned k = 0; k < COS_DEPTH; k++)
        begin
            rom[k] = cos_entry(k);
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// File: rtl/core/rwsp_front.sv
// Front stages: angle difference, cosine lookup, fisheye multiply, divider load.
// Depends on rwsp_pkg.
module rwsp_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [rwsp_pkg::COL_W-1:0]         column,
    input  logic [rwsp_pkg::DIST_W-1:0]        ray_distance,
    input  logic [rwsp_pkg::ANGLE_W-1:0]       ray_angle,
    input  logic [rwsp_pkg::ANGLE_W-1:0]       view_angle,
    input  logic                               hit_vertical,
    input  logic [rwsp_pkg::SCALE_W-1:0]       scale,
    output rwsp_pkg::div_t                     div_out
);

    logic                                a_valid_reg;
    logic [rwsp_pkg::COL_W-1:0]          a_column_reg;
    logic [rwsp_pkg::DIST_W-1:0]         a_dist_reg;
    logic [rwsp_pkg::COS_IDX_W-1:0]      a_idx_reg;
    logic                                a_vert_reg;
    logic [rwsp_pkg::ANGLE_W-1:0]        angle_diff;

    logic                                b_valid_reg;
    logic [rwsp_pkg::COL_W-1:0]          b_column_reg;
    logic [rwsp_pkg::DIST_W-1:0]         b_dist_reg;
    logic [rwsp_pkg::MAG_W-1:0]          b_mag_reg;
    logic                                b_vert_reg;
    logic                                b_empty_reg;
    rwsp_pkg::cos_entry_t                cos_val;
    logic                                b_empty_next;

    logic                                c_valid_reg;
    logic [rwsp_pkg::COL_W-1:0]          c_column_reg;
    logic [rwsp_pkg::DIST_W-1:0]         c_perp_reg;
    logic                                c_vert_reg;
    logic                                c_empty_reg;
    logic [rwsp_pkg::DIST_W+rwsp_pkg::MAG_W-1:0] product;

    rwsp_pkg::div_t                      d_reg;
    rwsp_pkg::div_t                      d_next;

    assign angle_diff = ray_angle - view_angle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_reg       <= '0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_reg       <= d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_column_reg <= column;
        a_dist_reg   <= ray_distance;
        a_idx_reg    <= angle_diff[rwsp_pkg::ANGLE_W-1 -: rwsp_pkg::COS_IDX_W];
        a_vert_reg   <= hit_vertical;
        b_column_reg <= a_column_reg;
        b_dist_reg   <= a_dist_reg;
        b_mag_reg    <= cos_val.mag;
        b_vert_reg   <= a_vert_reg;
        b_empty_reg  <= b_empty_next;
        c_column_reg <= b_column_reg;
        c_perp_reg   <= product[rwsp_pkg::COS_FRAC +: rwsp_pkg::DIST_W];
        c_vert_reg   <= b_vert_reg;
        c_empty_reg  <= b_empty_reg;
    end

    always_comb
    begin
        cos_val = rwsp_pkg::COS_ROM[a_idx_reg];
        b_empty_next = (32'(a_column_reg) >= rwsp_pkg::NUM_COLUMNS)
                    || (cos_val.neg && (a_dist_reg != '0));
    end

    assign product = b_dist_reg * b_mag_reg;

    always_comb
    begin
        d_next.ray.valid  = c_valid_reg;
        d_next.ray.column = c_column_reg;
        d_next.ray.vert   = c_vert_reg;
        d_next.ray.empty  = c_empty_reg;
        d_next.ray.full   = (c_perp_reg == '0);
        d_next.rem        = '0;
        d_next.dividend   = scale;
        d_next.divisor    = c_perp_reg;
        d_next.quot       = '0;
    end

    assign div_out = d_reg;

endmodule

// File: rtl/core/rwsp_div_cell.sv
// One cell of the divider chain: retires one quotient bit per item per cycle.
// Depends on rwsp_pkg.
module rwsp_div_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  rwsp_pkg::div_t div_in,
    output rwsp_pkg::div_t div_out
);

    rwsp_pkg::div_t              cell_reg;
    rwsp_pkg::div_t              cell_next;
    logic [rwsp_pkg::REM_W-1:0]  shifted;
    logic [rwsp_pkg::REM_W-1:0]  diff;
    logic                        take;

    always_comb
    begin
        shifted = {div_in.rem, div_in.dividend[rwsp_pkg::SCALE_W-1]};
        diff    = shifted - {1'b0, div_in.divisor};
        take    = (shifted >= {1'b0, div_in.divisor});
        cell_next          = div_in;
        cell_next.rem      = take ? diff[rwsp_pkg::DIST_W-1:0]
                                  : shifted[rwsp_pkg::DIST_W-1:0];
        cell_next.dividend = {div_in.dividend[rwsp_pkg::SCALE_W-2:0], 1'b0};
        cell_next.quot     = {div_in.quot[rwsp_pkg::SCALE_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign div_out = cell_reg;

endmodule

// File: rtl/core/rwsp_span.sv
// Span stage: turns the wall height into clamped top and bottom rows.
// Depends on rwsp_pkg.
module rwsp_span
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  rwsp_pkg::div_t                  div_in,
    input  logic [rwsp_pkg::COLOUR_W-1:0]   vert_colour,
    input  logic [rwsp_pkg::COLOUR_W-1:0]   horiz_colour,
    output logic                            done,
    output logic [rwsp_pkg::COL_W-1:0]      out_column,
    output logic [rwsp_pkg::ROW_W-1:0]      top_row,
    output logic [rwsp_pkg::ROW_W-1:0]      bottom_row,
    output logic [rwsp_pkg::COLOUR_W-1:0]   wall_colour
);

    localparam logic signed [rwsp_pkg::SPAN_W-1:0] MID =
        rwsp_pkg::SPAN_W'(rwsp_pkg::SCREEN_ROWS / 2);
    localparam logic signed [rwsp_pkg::SPAN_W-1:0] ROWS =
        rwsp_pkg::SPAN_W'(rwsp_pkg::SCREEN_ROWS);
    localparam logic [rwsp_pkg::SCALE_W-1:0] MAX_H =
        rwsp_pkg::SCALE_W'(2 * rwsp_pkg::SCREEN_ROWS);

    logic                                 done_reg;
    logic [rwsp_pkg::COL_W-1:0]           column_reg;
    logic [rwsp_pkg::ROW_W-1:0]           top_reg;
    logic [rwsp_pkg::ROW_W-1:0]           bottom_reg;
    logic [rwsp_pkg::COLOUR_W-1:0]        colour_reg;
    logic [rwsp_pkg::ROW_W-1:0]           top_next;
    logic [rwsp_pkg::ROW_W-1:0]           bottom_next;

    logic [rwsp_pkg::SCALE_W-1:0]         half_wide;
    logic signed [rwsp_pkg::SPAN_W-1:0]   half;
    logic signed [rwsp_pkg::SPAN_W-1:0]   top_s;
    logic signed [rwsp_pkg::SPAN_W-1:0]   bottom_s;

    always_comb
    begin
        half_wide = div_in.quot >> 1;
        half      = $signed(half_wide[rwsp_pkg::SPAN_W-1:0]);
        top_s     = MID - half;
        bottom_s  = MID + half;
        if (top_s < 0)
        begin
            top_s = '0;
        end
        if (bottom_s > ROWS)
        begin
            bottom_s = ROWS;
        end
        if (div_in.ray.empty)
        begin
            top_s    = MID;
            bottom_s = MID;
        end
        else if (div_in.ray.full || (div_in.quot > MAX_H))
        begin
            top_s    = '0;
            bottom_s = ROWS;
        end
        top_next    = top_s[rwsp_pkg::ROW_W-1:0];
        bottom_next = bottom_s[rwsp_pkg::ROW_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_in.ray.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        column_reg <= div_in.ray.column;
        top_reg    <= top_next;
        bottom_reg <= bottom_next;
        colour_reg <= div_in.ray.vert ? vert_colour : horiz_colour;
    end

    assign done        = done_reg;
    assign out_column  = column_reg;
    assign top_row     = top_reg;
    assign bottom_row  = bottom_reg;
    assign wall_colour = colour_reg;

endmodule

// File: rtl/core/raycast_wall_strip_projection.sv
// Raycast wall strip projection: one ray in, one clamped wall span out.
// The result passes through 4 front stages, 24 divider cells and 1 output stage;
// throughput one item per cycle while busy is low.
// The divider is a 24-cell restoring chain, one quotient bit a cell.
// Reset clears all valid flags and restores the config registers; busy is
// high during reset and until ready_reg is set. Results cannot be stalled.
`include "raycast_wall_strip_projection_macros.svh"

module raycast_wall_strip_projection
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cfg_we,
    input  logic [rwsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rwsp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [rwsp_pkg::COL_W-1:0]        column,
    input  logic [rwsp_pkg::DIST_W-1:0]       ray_distance,
    input  logic [rwsp_pkg::ANGLE_W-1:0]      ray_angle,
    input  logic [rwsp_pkg::ANGLE_W-1:0]      view_angle,
    input  logic                              hit_vertical,
    output logic                              done,
    output logic [rwsp_pkg::COL_W-1:0]        out_column,
    output logic [rwsp_pkg::ROW_W-1:0]        top_row,
    output logic [rwsp_pkg::ROW_W-1:0]        bottom_row,
    output logic [rwsp_pkg::COLOUR_W-1:0]     wall_colour
);

    localparam int LAT = rwsp_pkg::RESULT_LATENCY;

    logic                              ready_reg;
    logic [rwsp_pkg::SCALE_W-1:0]      scale_reg;
    logic [rwsp_pkg::COLOUR_W-1:0]     vert_colour_reg;
    logic [rwsp_pkg::COLOUR_W-1:0]     horiz_colour_reg;
    logic                              accept;
    rwsp_pkg::div_t                    chain [rwsp_pkg::DIV_CELLS+1];

    assign busy   = !ready_reg;
    assign accept = start && ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg        <= 1'b0;
            scale_reg        <= rwsp_pkg::SCALE_RESET;
            vert_colour_reg  <= rwsp_pkg::VERT_COLOUR_RESET;
            horiz_colour_reg <= rwsp_pkg::HORIZ_COLOUR_RESET;
        end
        else
        begin
            ready_reg <= 1'b1;
            if (cfg_we)
            begin
                unique case (rwsp_pkg::cfg_reg_t'(cfg_index))
                    rwsp_pkg::REG_SCALE:
                    begin
                        scale_reg <= cfg_data[rwsp_pkg::SCALE_W-1:0];
                    end
                    rwsp_pkg::REG_VERT_COLOUR:
                    begin
                        vert_colour_reg <= cfg_data[rwsp_pkg::COLOUR_W-1:0];
                    end
                    rwsp_pkg::REG_HORIZ_COLOUR:
                    begin
                        horiz_colour_reg <= cfg_data[rwsp_pkg::COLOUR_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    rwsp_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .column       (column),
        .ray_distance (ray_distance),
        .ray_angle    (ray_angle),
        .view_angle   (view_angle),
        .hit_vertical (hit_vertical),
        .scale        (scale_reg),
        .div_out      (chain[0])
    );

    for (genvar i = 0; i < rwsp_pkg::DIV_CELLS; i++)
    begin : g_cell
        rwsp_div_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .div_in  (chain[i]),
            .div_out (chain[i+1])
        );
    end

    rwsp_span u_span
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .div_in       (chain[rwsp_pkg::DIV_CELLS]),
        .vert_colour  (vert_colour_reg),
        .horiz_colour (horiz_colour_reg),
        .done         (done),
        .out_column   (out_column),
        .top_row      (top_row),
        .bottom_row   (bottom_row),
        .wall_colour  (wall_colour)
    );

    `RWSP_ASSERT(a_result_follows_item, (start && !busy) |-> ##LAT done)
    `RWSP_ASSERT(a_result_has_item, done |-> $past(start && !busy, LAT))
    `RWSP_ASSERT_NEVER(a_span_inverted, done && (top_row > bottom_row))

endmodule
